// File: sv/rad_pkg.sv
// package for the rom address descrambler: bit orders, byte xor tables and
// the bit permutation helpers; no dependencies
`timescale 1ns / 1ps

package rad_pkg;

  localparam int unsigned AddrWidth  = 19;
  localparam int unsigned KeyWidth   = 16;
  localparam int unsigned LowWidth   = 16;
  localparam int unsigned BlkWidth   = AddrWidth - LowWidth;
  localparam int unsigned NumBlocks  = 1 << BlkWidth;

  typedef logic [3:0] bit_sel_t;
  typedef bit_sel_t   bit_order_t [16];

  typedef logic [AddrWidth-1:0] addr_t;
  typedef logic [KeyWidth-1:0]  key_t;
  typedef logic [LowWidth-1:0]  low_t;
  typedef logic [BlkWidth-1:0]  blk_t;

  // result bit j takes source bit BLOCK_ORDER[blk][j]
  localparam bit_order_t BLOCK_ORDER [NumBlocks] = '{
    '{4'd15, 4'd14, 4'd10, 4'd7,  4'd1,  4'd2,  4'd3,  4'd8,
      4'd0,  4'd12, 4'd11, 4'd13, 4'd6,  4'd9,  4'd5,  4'd4},
    '{4'd7,  4'd1,  4'd8,  4'd11, 4'd15, 4'd9,  4'd2,  4'd3,
      4'd5,  4'd13, 4'd4,  4'd14, 4'd10, 4'd0,  4'd6,  4'd12},
    '{4'd8,  4'd6,  4'd14, 4'd3,  4'd10, 4'd7,  4'd15, 4'd1,
      4'd4,  4'd0,  4'd2,  4'd5,  4'd13, 4'd11, 4'd12, 4'd9},
    '{4'd2,  4'd8,  4'd15, 4'd9,  4'd3,  4'd4,  4'd11, 4'd7,
      4'd13, 4'd6,  4'd0,  4'd10, 4'd1,  4'd12, 4'd14, 4'd5},
    '{4'd1,  4'd13, 4'd6,  4'd15, 4'd14, 4'd3,  4'd8,  4'd10,
      4'd9,  4'd4,  4'd7,  4'd12, 4'd5,  4'd2,  4'd0,  4'd11},
    '{4'd11, 4'd15, 4'd3,  4'd4,  4'd7,  4'd0,  4'd9,  4'd2,
      4'd6,  4'd14, 4'd12, 4'd1,  4'd8,  4'd5,  4'd10, 4'd13},
    '{4'd10, 4'd5,  4'd13, 4'd8,  4'd6,  4'd15, 4'd1,  4'd14,
      4'd11, 4'd9,  4'd3,  4'd0,  4'd12, 4'd7,  4'd4,  4'd2},
    '{4'd9,  4'd3,  4'd7,  4'd0,  4'd2,  4'd12, 4'd4,  4'd11,
      4'd14, 4'd10, 4'd5,  4'd8,  4'd15, 4'd13, 4'd1,  4'd6}
  };

  // entry i gives the source of result bit 15-i
  localparam bit_order_t KEY_PERM = '{
    4'd12, 4'd0,  4'd2,  4'd4,  4'd8,  4'd15, 4'd7,  4'd13,
    4'd10, 4'd1,  4'd3,  4'd6,  4'd11, 4'd9,  4'd14, 4'd5
  };

  localparam bit_order_t OUT_PERM = '{
    4'd7,  4'd15, 4'd14, 4'd6,  4'd5,  4'd13, 4'd12, 4'd4,
    4'd11, 4'd3,  4'd10, 4'd2,  4'd9,  4'd1,  4'd8,  4'd0
  };

  // xor for the high byte, indexed by the low byte
  localparam logic [7:0] HIGH_BYTE_XOR [256] = '{
    8'h0a,8'h72,8'hb7,8'haf,8'h67,8'hde,8'h1d,8'hb1,8'h78,8'hc4,8'h4f,8'hb5,8'h4b,8'h18,8'h76,8'hdd,
    8'h11,8'he2,8'h36,8'ha1,8'h82,8'h03,8'h98,8'ha0,8'h10,8'h5f,8'h3f,8'hd6,8'h1f,8'h90,8'h6a,8'h0b,
    8'h70,8'he0,8'h64,8'hcb,8'h9f,8'h38,8'h8b,8'h53,8'h04,8'hca,8'hf8,8'hd0,8'h07,8'h68,8'h56,8'h32,
    8'hae,8'h1c,8'h2e,8'h48,8'h63,8'h92,8'h9a,8'h9c,8'h44,8'h85,8'h41,8'h40,8'h09,8'hc0,8'hc8,8'hbf,
    8'hea,8'hbb,8'hf7,8'h2d,8'h99,8'h21,8'hf6,8'hba,8'h15,8'hce,8'hab,8'hb0,8'h2a,8'h60,8'hbc,8'hf1,
    8'hf0,8'h9e,8'hd5,8'h97,8'hd8,8'h4e,8'h14,8'h9d,8'h42,8'h4d,8'h2c,8'h5c,8'h2b,8'ha6,8'he1,8'ha7,
    8'hef,8'h25,8'h33,8'h7a,8'heb,8'he7,8'h1b,8'h6d,8'h4c,8'h52,8'h26,8'h62,8'hb6,8'h35,8'hbe,8'h80,
    8'h01,8'hbd,8'hfd,8'h37,8'hf9,8'h47,8'h55,8'h71,8'hb4,8'hf2,8'hff,8'h27,8'hfa,8'h23,8'hc9,8'h83,
    8'h17,8'h39,8'h13,8'h0d,8'hc7,8'h86,8'h16,8'hec,8'h49,8'h6f,8'hfe,8'h34,8'h05,8'h8f,8'h00,8'he6,
    8'ha4,8'hda,8'h7b,8'hc1,8'hf3,8'hf4,8'hd9,8'h75,8'h28,8'h66,8'h87,8'ha8,8'h45,8'h6c,8'h20,8'he9,
    8'h77,8'h93,8'h7e,8'h3c,8'h1e,8'h74,8'hf5,8'h8c,8'h3e,8'h94,8'hd4,8'hc2,8'h5a,8'h06,8'h0e,8'he8,
    8'h3d,8'ha9,8'hb2,8'he3,8'he4,8'h22,8'hcf,8'h24,8'h8e,8'h6b,8'h8a,8'h8d,8'h84,8'h4a,8'hd2,8'h91,
    8'h88,8'h79,8'h57,8'ha5,8'h0f,8'hcd,8'hb9,8'hac,8'h3b,8'haa,8'hb3,8'hd1,8'hee,8'h31,8'h81,8'h7c,
    8'hd7,8'h89,8'hd3,8'h96,8'h43,8'hc5,8'hc6,8'hc3,8'h69,8'h7f,8'h46,8'hdf,8'h30,8'h5b,8'h6e,8'he5,
    8'h08,8'h95,8'h9b,8'hfb,8'hb8,8'h58,8'h0c,8'h61,8'h50,8'h5d,8'h3a,8'ha2,8'h29,8'h12,8'hfc,8'h51,
    8'h7d,8'h1a,8'h02,8'h65,8'h54,8'h5e,8'h19,8'hcc,8'hdc,8'hdb,8'h73,8'hed,8'had,8'h59,8'h2f,8'ha3
  };

  // xor for the low byte, indexed by the high byte
  localparam logic [7:0] LOW_BYTE_XOR [256] = '{
    8'hf4,8'hbc,8'h02,8'hf7,8'h2c,8'h3d,8'he8,8'hd9,8'h50,8'h62,8'hec,8'hbd,8'h53,8'h73,8'h79,8'h61,
    8'h00,8'h34,8'hcf,8'ha2,8'h63,8'h28,8'h90,8'haf,8'h44,8'h3b,8'hc5,8'h8d,8'h3a,8'h46,8'h07,8'h70,
    8'h66,8'hbe,8'hd8,8'h8b,8'he9,8'ha0,8'h4b,8'h98,8'hdc,8'hdf,8'he2,8'h16,8'h74,8'hf1,8'h37,8'hf5,
    8'hb7,8'h21,8'h81,8'h01,8'h1c,8'h1b,8'h94,8'h36,8'h09,8'ha1,8'h4a,8'h91,8'h30,8'h92,8'h9b,8'h9a,
    8'h29,8'hb1,8'h38,8'h4d,8'h55,8'hf2,8'h56,8'h18,8'h24,8'h47,8'h9d,8'h3f,8'h80,8'h1f,8'h22,8'ha4,
    8'h11,8'h54,8'h84,8'h0d,8'h25,8'h48,8'hee,8'hc6,8'h59,8'h15,8'h03,8'h7a,8'hfd,8'h6c,8'hc3,8'h33,
    8'h5b,8'hc4,8'h7b,8'h5a,8'h05,8'h7f,8'ha6,8'h40,8'ha9,8'h5d,8'h41,8'h8a,8'h96,8'h52,8'hd3,8'hf0,
    8'hab,8'h72,8'h10,8'h88,8'h6f,8'h95,8'h7c,8'ha8,8'hcd,8'h9c,8'h5f,8'h32,8'hae,8'h85,8'h39,8'hac,
    8'he5,8'hd7,8'hfb,8'hd4,8'h08,8'h23,8'h19,8'h65,8'h6b,8'ha7,8'h93,8'hbb,8'h2b,8'hbf,8'hb8,8'h35,
    8'hd0,8'h06,8'h26,8'h68,8'h3e,8'hdd,8'hb9,8'h69,8'h2a,8'hb2,8'hde,8'h87,8'h45,8'h58,8'hff,8'h3c,
    8'h9e,8'h7d,8'hda,8'hed,8'h49,8'h8c,8'h14,8'h8e,8'h75,8'h2f,8'he0,8'h6e,8'h78,8'h6d,8'h20,8'hd2,
    8'hfa,8'h2d,8'h51,8'hcc,8'hc7,8'he7,8'h1d,8'h27,8'h97,8'hfc,8'h31,8'hdb,8'hf8,8'h42,8'he3,8'h99,
    8'h5e,8'h83,8'h0e,8'hb4,8'h2e,8'hf6,8'hc0,8'h0c,8'h4c,8'h57,8'hb6,8'h64,8'h0a,8'h17,8'ha3,8'hc1,
    8'h77,8'h12,8'hfe,8'he6,8'h8f,8'h13,8'h71,8'he4,8'hf9,8'had,8'h9f,8'hce,8'hd5,8'h89,8'h7e,8'h0f,
    8'hc2,8'h86,8'hf3,8'h67,8'hba,8'h60,8'h43,8'hc9,8'h04,8'hb3,8'hb0,8'h1e,8'hb5,8'hc8,8'heb,8'ha5,
    8'h76,8'hea,8'h5c,8'h82,8'h1a,8'h4f,8'haa,8'hca,8'he1,8'h0b,8'h4e,8'hcb,8'h6a,8'hef,8'hd1,8'hd6
  };

  // result bit 15-i takes source bit ord[i]
  function automatic low_t perm_msb_first(input low_t x, input bit_order_t ord);
    low_t r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[15-i] = x[ord[i]];
    end
    return r;
  endfunction

  // result bit i takes source bit ord[i]
  function automatic low_t perm_lsb_first(input low_t x, input bit_order_t ord);
    low_t r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[i] = x[ord[i]];
    end
    return r;
  endfunction

endpackage

// File: sv/rad_key_reg.sv
// key register: holds the key already passed through its fixed bit order
// depends on rad_pkg
`timescale 1ns / 1ps

module rad_key_reg import rad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  input  key_t cfg_data_i,
  output logic cfg_ready_o,
  output low_t key_perm_o
);

  low_t key_perm_q, key_perm_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_perm_d = key_perm_q;
    if (cfg_valid_i) begin
      key_perm_d = perm_msb_first(cfg_data_i, KEY_PERM);
    end
  end

  // permutation of an all-zero key is zero, so reset matches a zero key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_perm_q <= '0;
    end else begin
      key_perm_q <= key_perm_d;
    end
  end

  assign key_perm_o = key_perm_q;

endmodule

// File: sv/rad_scramble.sv
// combinational address scramble between the input and result registers
// depends on rad_pkg
`timescale 1ns / 1ps

module rad_scramble import rad_pkg::*; (
  input  addr_t addr_i,
  input  low_t  key_perm_i,
  output addr_t addr_o
);

  blk_t       blk;
  low_t       keyed;
  low_t       ordered;
  logic [7:0] lo_byte;
  logic [7:0] hi_byte;
  low_t       mixed;

  always_comb begin
    blk     = addr_i[AddrWidth-1:LowWidth];
    keyed   = addr_i[LowWidth-1:0] ^ key_perm_i;
    ordered = perm_lsb_first(keyed, BLOCK_ORDER[blk]);
    // low byte first, then the high byte keyed by the new low byte
    lo_byte = ordered[7:0] ^ LOW_BYTE_XOR[ordered[15:8]];
    hi_byte = ordered[15:8] ^ HIGH_BYTE_XOR[lo_byte];
    mixed   = perm_msb_first({hi_byte, lo_byte}, OUT_PERM);
    addr_o  = {blk, mixed};
  end

endmodule

// File: sv/rom_address_descrambler.sv
// top level of the rom address descrambler: input register, scramble logic,
// result register and the key register; depends on rad_pkg and its submodules
`timescale 1ns / 1ps

// Maps a 19-bit linear ROM address to the scrambled source address of the
// byte. One address is taken every clock cycle (busy_o never rises) and its
// result passes from the input register through the scramble logic into the
// result register. Each result is shown on source_address_o for exactly one
// cycle with done_o high; the receiver cannot stall, so it must take every
// result as it comes. The user must write the key through the cfg channel
// (always ready) only while no address is in flight; the block itself does
// not enforce this. The key takes effect from the next accepted address.
module rom_address_descrambler import rad_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  // command side
  input  logic  start_i,
  output logic  busy_o,
  input  addr_t rom_address_i,
  // result side
  output logic  done_o,
  output addr_t source_address_o,
  // key write channel
  input  logic  cfg_valid_i,
  output logic  cfg_ready_o,
  input  key_t  cfg_data_i
);

  // every stage advances each cycle, so there is never back pressure
  assign busy_o = 1'b0;

  logic  in_valid_q, in_valid_d;
  addr_t in_addr_q, in_addr_d;
  logic  done_q, done_d;
  addr_t out_addr_q, out_addr_d;
  low_t  key_perm;
  addr_t scrambled;

  // key register with its fixed bit order applied at write time
  rad_key_reg u_key_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .key_perm_o  (key_perm)
  );

  // whole scramble in one pass
  rad_scramble u_scramble (
    .addr_i     (in_addr_q),
    .key_perm_i (key_perm),
    .addr_o     (scrambled)
  );

  always_comb begin
    in_valid_d = start_i & ~busy_o;
    in_addr_d  = in_addr_q;
    if (start_i && !busy_o) begin
      in_addr_d = rom_address_i;
    end
    done_d     = in_valid_q;
    out_addr_d = out_addr_q;
    if (in_valid_q) begin
      out_addr_d = scrambled;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      done_q     <= done_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    in_addr_q  <= in_addr_d;
    out_addr_q <= out_addr_d;
  end

  assign done_o           = done_q;
  assign source_address_o = out_addr_q;

endmodule
